[hw/rtl/mbpes_pkg.sv]
`timescale 1ns / 1ps

package mbpes_pkg;

    localparam int MAX_LANES = 8;
    localparam int CNT_W     = 16;
    localparam int NUM_W     = 4;
    localparam int BIDX_W    = 3;
    localparam int DIV_STEPS = CNT_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_CLICK_DOWN  = 3'd1,
        EV_HOLD_START  = 3'd2,
        EV_HOLD_REPEAT = 3'd3,
        EV_CLICK_UP    = 3'd4,
        EV_HOLD_UP     = 3'd5
    } event_t;

    typedef enum logic [2:0] {
        CFG_ACTIVE_COUNT      = 3'd0,
        CFG_PRESS_LEVEL_MASK  = 3'd1,
        CFG_DOWN_TICKS        = 3'd2,
        CFG_HOLD_TICKS        = 3'd3,
        CFG_HOLD_REPEAT_TICKS = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0] down_ticks;
        logic [CNT_W-1:0] hold_ticks;
        logic [CNT_W-1:0] hold_repeat_ticks;
    } scan_cfg_t;

    typedef struct packed {
        event_t ev;
        logic   note;
    } lane_res_t;

endpackage

[hw/rtl/mbpes_lane.sv]
`timescale 1ns / 1ps

module mbpes_lane
    import mbpes_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      active,
    input  logic      pin,
    input  logic      level,
    input  scan_cfg_t cfg,
    output lane_res_t res,
    output logic      busy
);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    lane_res_t         res_reg, res_next;
    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvd_reg, dvd_next;
    logic              pressed;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W:0]    rem_shift;
    logic [CNT_W:0]    rem_sub;

    assign pressed   = (pin == level);
    assign cnt_inc   = cnt_reg + 1'b1;
    assign rem_shift = {rem_reg, dvd_reg[CNT_W-1]};
    assign rem_sub   = rem_shift - {1'b0, cfg.hold_repeat_ticks};

    always_comb
    begin
        cnt_next  = cnt_reg;
        res_next  = res_reg;
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        if (start && active)
        begin
            res_next.ev   = EV_NONE;
            res_next.note = 1'b0;
            if (pressed)
            begin
                cnt_next = cnt_inc;
                if (cnt_inc == cfg.down_ticks)
                begin
                    res_next.ev   = EV_CLICK_DOWN;
                    res_next.note = 1'b1;
                end
                else if (cnt_inc == cfg.hold_ticks)
                begin
                    res_next.ev   = EV_HOLD_START;
                    res_next.note = 1'b1;
                end
                else if (cnt_inc > cfg.hold_ticks)
                begin
                    res_next.ev = EV_HOLD_REPEAT;
                    if (cfg.hold_repeat_ticks != '0)
                    begin
                        busy_next = 1'b1;
                        step_next = '0;
                        rem_next  = '0;
                        dvd_next  = cnt_inc;
                    end
                end
            end
            else
            begin
                cnt_next = '0;
                if (cnt_reg >= cfg.down_ticks && cnt_reg < cfg.hold_ticks)
                begin
                    res_next.ev   = EV_CLICK_UP;
                    res_next.note = 1'b1;
                end
                else if (cnt_reg >= cfg.hold_ticks)
                begin
                    res_next.ev   = EV_HOLD_UP;
                    res_next.note = 1'b1;
                end
            end
        end
        else if (busy_reg)
        begin
            // restoring remainder, one dividend bit per cycle
            if (!rem_sub[CNT_W])
                rem_next = rem_sub[CNT_W-1:0];
            else
                rem_next = rem_shift[CNT_W-1:0];
            dvd_next  = {dvd_reg[CNT_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIV_STEPS - 1))
            begin
                busy_next     = 1'b0;
                res_next.note = (rem_next == '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    assign res  = res_reg;
    assign busy = busy_reg;

endmodule

[hw/rtl/mbpes_merge.sv]
`timescale 1ns / 1ps

module mbpes_merge
    import mbpes_pkg::*;
#(
    parameter int LANES = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [NUM_W-1:0]  count,
    input  lane_res_t         res [LANES],
    input  logic              out_ready,
    output logic              out_valid,
    output logic [BIDX_W-1:0] button_index,
    output logic [2:0]        event_code,
    output logic              notify,
    output logic              last
);

    localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_inc;
    logic              valid_reg;
    logic              last_reg;
    lane_res_t         data_reg;
    logic [NUM_W-1:0]  pos_after;

    assign idx_inc   = idx_reg + 1'b1;
    assign pos_after = NUM_W'(idx_inc) + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
            last_reg  <= (count == NUM_W'(1));
        end
        else if (valid_reg && out_ready)
        begin
            if (last_reg)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg  <= idx_inc;
                last_reg <= (pos_after == count);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res[0];
        else if (valid_reg && out_ready && !last_reg)
            data_reg <= res[idx_inc];
    end

    assign out_valid    = valid_reg;
    assign button_index = BIDX_W'(idx_reg);
    assign event_code   = data_reg.ev;
    assign notify       = data_reg.note;
    assign last         = last_reg;

endmodule

[hw/rtl/multi_button_press_event_scanner_unit.sv]
`timescale 1ns / 1ps
// flow: an accepted input item is registered in the lanes (ST_CALC), waits while a
// hold-repeat lane runs its 16-step remainder unit, then loads the merge output register
// throughput: one result per cycle while out_ready is high; a new item is taken only
// after the last result of the current one has been transferred
// reset: asynchronous, clears press counters and loads register reset values

module multi_button_press_event_scanner_unit
    import mbpes_pkg::*;
#(
    parameter int NUM_BUTTONS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        pin_levels,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BIDX_W-1:0] button_index,
    output logic [2:0]        event_code,
    output logic              notify,
    output logic              last
);

    localparam int LANES = (NUM_BUTTONS < MAX_LANES) ? NUM_BUTTONS : MAX_LANES;

    logic [NUM_W-1:0]  active_count_reg;
    logic [7:0]        press_level_mask_reg;
    scan_cfg_t         cfg_reg;
    state_t            state_reg, state_next;
    logic [NUM_W-1:0]  num_scan;
    logic              start;
    logic              load;
    logic [LANES-1:0]  lane_busy;
    lane_res_t         lane_res [LANES];

    assign cfg_ready = 1'b1;
    assign num_scan  = (active_count_reg > NUM_W'(LANES)) ? NUM_W'(LANES) : active_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_count_reg           <= '0;
            press_level_mask_reg       <= '0;
            cfg_reg.down_ticks         <= 16'd2;
            cfg_reg.hold_ticks         <= 16'd100;
            cfg_reg.hold_repeat_ticks  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ACTIVE_COUNT:      active_count_reg          <= cfg_data[NUM_W-1:0];
                CFG_PRESS_LEVEL_MASK:  press_level_mask_reg      <= cfg_data[7:0];
                CFG_DOWN_TICKS:        cfg_reg.down_ticks        <= cfg_data;
                CFG_HOLD_TICKS:        cfg_reg.hold_ticks        <= cfg_data;
                CFG_HOLD_REPEAT_TICKS: cfg_reg.hold_repeat_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        start      = 1'b0;
        load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                start    = in_valid;
                if (in_valid && num_scan != '0)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (!(|lane_busy))
                begin
                    load       = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_valid && out_ready && last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        mbpes_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (start),
            .active (NUM_W'(i) < num_scan),
            .pin    (pin_levels[i]),
            .level  (press_level_mask_reg[i]),
            .cfg    (cfg_reg),
            .res    (lane_res[i]),
            .busy   (lane_busy[i])
        );
    end

    mbpes_merge #(
        .LANES (LANES)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .count        (num_scan),
        .res          (lane_res),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .button_index (button_index),
        .event_code   (event_code),
        .notify       (notify),
        .last         (last)
    );

endmodule

[hw/rtl/mbpes_checker.sv]
`timescale 1ns / 1ps

module mbpes_checker
    import mbpes_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [BIDX_W-1:0] button_index,
    input logic [2:0]        event_code,
    input logic              notify,
    input logic              last
);

    // no new item while results of the current one are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while results pending");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> !out_valid)
        else $error("result after last");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=>
            out_valid && button_index == BIDX_W'($past(button_index) + 1'b1))
        else $error("button index out of order");

    a_none_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_code == EV_NONE |-> !notify)
        else $error("notify without event");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(button_index)
            && $stable(event_code) && $stable(notify) && $stable(last))
        else $error("stalled result changed");

endmodule

bind multi_button_press_event_scanner_unit mbpes_checker u_mbpes_checker (.*);

[bench/tb_multi_button_press_event_scanner_unit.sv]
`timescale 1ns / 1ps

module tb_multi_button_press_event_scanner_unit;
    import mbpes_pkg::*;

    localparam int NUM_BTN     = 8;
    localparam int SCAN_LANES  = (NUM_BTN < MAX_LANES) ? NUM_BTN : MAX_LANES;
    localparam int SETTLE_CYC  = 40;
    localparam int STALL_CYC   = 400;
    localparam int PHASE_ITEMS = 52;
    localparam int TAIL_ITEMS  = 40;

    localparam logic [2:0] CFG_IDX_SPARE = 3'd7;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PREDICT,
        ROW_NO_RESULT,
        ROW_ONE_RESULT
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  idx;
        logic [15:0] data;
        logic [7:0]  pins;
        event_t      ev;
        logic        note;
    } stim_row_t;

    typedef struct packed {
        logic [BIDX_W-1:0] idx;
        event_t            ev;
        logic              note;
        logic              last;
    } scan_result_t;

    localparam int N_ROWS = 32;
    localparam stim_row_t DIRECTED [N_ROWS] = '{
        '{ROW_NO_RESULT,  3'd0, 16'h0000, 8'hFF, EV_NONE, 1'b0},
        '{ROW_CFG, CFG_ACTIVE_COUNT, 16'h0001, 8'h00, EV_NONE, 1'b0},
        '{ROW_CFG, CFG_PRESS_LEVEL_MASK, 16'h0001, 8'h00, EV_NONE, 1'b0},
        '{ROW_ONE_RESULT, 3'd0, 16'h0000, 8'h01, EV_NONE, 1'b0},
        '{ROW_ONE_RESULT, 3'd0, 16'h0000, 8'h01, EV_CLICK_DOWN, 1'b1},
        '{ROW_ONE_RESULT, 3'd0, 16'h0000, 8'h00, EV_CLICK_UP, 1'b1},
        '{ROW_ONE_RESULT, 3'd0, 16'h0000, 8'h00, EV_NONE, 1'b0},
        '{ROW_CFG, CFG_HOLD_TICKS, 16'h0004, 8'h00, EV_NONE, 1'b0},
        '{ROW_CFG, CFG_HOLD_REPEAT_TICKS, 16'h0002, 8'h00, EV_NONE, 1'b0},
        '{ROW_ONE_RESULT, 3'd0, 16'h0000, 8'hFF, EV_NONE, 1'b0},
        '{ROW_ONE_RESULT, 3'd0, 16'h0000, 8'h01, EV_CLICK_DOWN, 1'b1},
        '{ROW_ONE_RESULT, 3'd0, 16'h0000, 8'h01, EV_NONE, 1'b0},
        '{ROW_ONE_RESULT, 3'd0, 16'h0000, 8'h01, EV_HOLD_START, 1'b1},
        '{ROW_ONE_RESULT, 3'd0, 16'h0000, 8'h01, EV_HOLD_REPEAT, 1'b0},
        '{ROW_ONE_RESULT, 3'd0, 16'h0000, 8'h01, EV_HOLD_REPEAT, 1'b1},
        '{ROW_ONE_RESULT, 3'd0, 16'h0000, 8'h00, EV_HOLD_UP, 1'b1},
        '{ROW_ONE_RESULT, 3'd0, 16'h0000, 8'h01, EV_NONE, 1'b0},
        '{ROW_ONE_RESULT, 3'd0, 16'h0000, 8'h00, EV_NONE, 1'b0},
        '{ROW_CFG, CFG_HOLD_REPEAT_TICKS, 16'h0000, 8'h00, EV_NONE, 1'b0},
        '{ROW_CFG, CFG_HOLD_TICKS, 16'h0001, 8'h00, EV_NONE, 1'b0},
        '{ROW_ONE_RESULT, 3'd0, 16'h0000, 8'h01, EV_HOLD_START, 1'b1},
        '{ROW_ONE_RESULT, 3'd0, 16'h0000, 8'h01, EV_CLICK_DOWN, 1'b1},
        '{ROW_ONE_RESULT, 3'd0, 16'h0000, 8'h01, EV_HOLD_REPEAT, 1'b0},
        '{ROW_ONE_RESULT, 3'd0, 16'h0000, 8'h00, EV_HOLD_UP, 1'b1},
        '{ROW_CFG, CFG_IDX_SPARE, 16'hFFFF, 8'h00, EV_NONE, 1'b0},
        '{ROW_CFG, CFG_ACTIVE_COUNT, 16'hFFFF, 8'h00, EV_NONE, 1'b0},
        '{ROW_CFG, CFG_PRESS_LEVEL_MASK, 16'hFF5A, 8'h00, EV_NONE, 1'b0},
        '{ROW_PREDICT, 3'd0, 16'h0000, 8'h00, EV_NONE, 1'b0},
        '{ROW_PREDICT, 3'd0, 16'h0000, 8'hFF, EV_NONE, 1'b0},
        '{ROW_PREDICT, 3'd0, 16'h0000, 8'h5A, EV_NONE, 1'b0},
        '{ROW_PREDICT, 3'd0, 16'h0000, 8'hA5, EV_NONE, 1'b0},
        '{ROW_PREDICT, 3'd0, 16'h0000, 8'h5A, EV_NONE, 1'b0}
    };

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [2:0]        cfg_index;
    logic [15:0]       cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [7:0]        pin_levels;
    logic              out_valid;
    logic              out_ready;
    logic [BIDX_W-1:0] button_index;
    logic [2:0]        event_code;
    logic              notify;
    logic              last;

    // tag of the item on offer, moves with the payload
    row_kind_t cur_kind;
    event_t    cur_ev;
    logic      cur_note;

    // predictor state
    logic [NUM_W-1:0] cfg_active = '0;
    logic [7:0]       cfg_mask   = '0;
    logic [15:0]      cfg_down   = 16'd2;
    logic [15:0]      cfg_hold   = 16'd100;
    logic [15:0]      cfg_rep    = '0;
    logic [15:0]      press_cnt [MAX_LANES];
    scan_result_t     pending_events [$];

    // stimulus plan for the current phase
    logic [7:0]  plan_mask;
    int          plan_down;
    int          plan_hold;
    int          plan_rep;
    bit          lane_down [MAX_LANES];
    int          lane_left [MAX_LANES];

    bit idle_on       = 1'b1;
    bit sink_hold_req = 1'b0;
    int errors        = 0;

    multi_button_press_event_scanner_unit #(
        .NUM_BUTTONS (NUM_BTN)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pin_levels   (pin_levels),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .button_index (button_index),
        .event_code   (event_code),
        .notify       (notify),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] d);
        case (idx)
            CFG_ACTIVE_COUNT:      cfg_active = d[NUM_W-1:0];
            CFG_PRESS_LEVEL_MASK:  cfg_mask   = d[7:0];
            CFG_DOWN_TICKS:        cfg_down   = d;
            CFG_HOLD_TICKS:        cfg_hold   = d;
            CFG_HOLD_REPEAT_TICKS: cfg_rep    = d;
            default: ;
        endcase
    endfunction

    function automatic void scan_buttons(input logic [7:0] pins, input bit keep);
        int           n;
        logic [15:0]  old_c;
        logic [15:0]  c;
        scan_result_t res;
        n = (int'(cfg_active) > SCAN_LANES) ? SCAN_LANES : int'(cfg_active);
        for (int i = 0; i < n; i++)
        begin
            old_c    = press_cnt[i];
            res.ev   = EV_NONE;
            res.note = 1'b0;
            if (pins[i] == cfg_mask[i])
            begin
                c            = old_c + 16'd1;
                press_cnt[i] = c;
                if (c == cfg_down)
                begin
                    res.ev   = EV_CLICK_DOWN;
                    res.note = 1'b1;
                end
                else if (c == cfg_hold)
                begin
                    res.ev   = EV_HOLD_START;
                    res.note = 1'b1;
                end
                else if (c > cfg_hold)
                begin
                    res.ev   = EV_HOLD_REPEAT;
                    res.note = (cfg_rep != 16'd0) && ((c % cfg_rep) == 16'd0);
                end
            end
            else
            begin
                press_cnt[i] = '0;
                if (old_c >= cfg_down && old_c < cfg_hold)
                begin
                    res.ev   = EV_CLICK_UP;
                    res.note = 1'b1;
                end
                else if (old_c >= cfg_hold)
                begin
                    res.ev   = EV_HOLD_UP;
                    res.note = 1'b1;
                end
            end
            res.idx  = BIDX_W'(i);
            res.last = (i == n - 1);
            if (keep)
                pending_events.push_back(res);
        end
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    // scoreboard and predictor, sampled at the edge
    always @(posedge clk)
    begin
        scan_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_events.size() == 0)
                begin
                    errors++;
                    $error("result transfer with nothing pending: button %0d event %0d",
                           button_index, event_code);
                end
                else
                begin
                    want = pending_events.pop_front();
                    check_field("button_index", want.idx, button_index);
                    check_field("event_code", want.ev, event_code);
                    check_field("notify", want.note, notify);
                    check_field("last", want.last, last);
                end
            end
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
            begin
                scan_buttons(pin_levels, cur_kind == ROW_PREDICT);
                if (cur_kind == ROW_ONE_RESULT)
                    pending_events.push_back('{'0, cur_ev, cur_note, 1'b1});
            end
        end
    end

    // result side back-pressure
    initial
    begin
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (sink_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (STALL_CYC) @(posedge clk);
                sink_hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    task automatic wait_idle();
        in_valid <= 1'b0;
        // let the scoreboard book the last transfer first
        @(posedge clk);
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic send_scan(input logic [7:0] pins, input row_kind_t kind,
                             input event_t ev, input logic note);
        cfg_valid  <= 1'b0;
        in_valid   <= 1'b1;
        pin_levels <= pins;
        cur_kind   <= kind;
        cur_ev     <= ev;
        cur_note   <= note;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic set_regs(input logic [3:0] act, input logic [7:0] mask,
                            input logic [15:0] down, input logic [15:0] hold,
                            input logic [15:0] rep);
        wait_idle();
        write_reg(CFG_ACTIVE_COUNT, {12'($urandom), act});
        write_reg(CFG_PRESS_LEVEL_MASK, {8'($urandom), mask});
        write_reg(CFG_DOWN_TICKS, down);
        write_reg(CFG_HOLD_TICKS, hold);
        write_reg(CFG_HOLD_REPEAT_TICKS, rep);
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_SPARE - 3'($urandom_range(0, 2)), 16'($urandom));
        plan_mask = mask;
        plan_down = down;
        plan_hold = hold;
        plan_rep  = rep;
        for (int k = 0; k < MAX_LANES; k++)
        begin
            lane_down[k] = 1'b0;
            lane_left[k] = $urandom_range(1, 3);
        end
    endtask

    function automatic logic [15:0] rand_tick(input int lim);
        if ($urandom_range(0, 5) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, lim));
    endfunction

    // press lengths aimed at the click, hold and repeat thresholds
    function automatic int press_len();
        int len;
        case ($urandom_range(0, 3))
            0:       len = $urandom_range(1, 3);
            1:       len = plan_down + $urandom_range(0, 2);
            2:       len = plan_hold + $urandom_range(0, 3 * (plan_rep % 64) + 3);
            default: len = $urandom_range(1, 40);
        endcase
        if (len > 300)
            len = $urandom_range(1, 300);
        if (len < 1)
            len = 1;
        return len;
    endfunction

    function automatic logic [7:0] next_pins();
        logic [7:0] p;
        for (int k = 0; k < MAX_LANES; k++)
        begin
            if (lane_left[k] == 0)
            begin
                lane_down[k] = !lane_down[k];
                lane_left[k] = lane_down[k] ? press_len() : $urandom_range(1, 4);
            end
            lane_left[k]--;
            p[k] = lane_down[k] ? plan_mask[k] : !plan_mask[k];
        end
        if ($urandom_range(0, 9) == 0)
            p = 8'($urandom);
        return p;
    endfunction

    initial
    begin
        for (int k = 0; k < MAX_LANES; k++)
            press_cnt[k] = '0;
        rst_n      <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        pin_levels <= '0;
        cur_kind   <= ROW_PREDICT;
        cur_ev     <= EV_NONE;
        cur_note   <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_ROWS; r++)
        begin
            if (DIRECTED[r].kind == ROW_CFG)
            begin
                if (r == 0 || DIRECTED[r-1].kind != ROW_CFG)
                    wait_idle();
                write_reg(DIRECTED[r].idx, DIRECTED[r].data);
            end
            else
            begin
                send_scan(DIRECTED[r].pins, DIRECTED[r].kind, DIRECTED[r].ev,
                          DIRECTED[r].note);
            end
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       set_regs(4'd8, 8'($urandom), 16'd2, 16'd12, 16'd3);
                1:       set_regs(4'hF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2:       set_regs(4'd1, 8'h00, 16'h0000, 16'h0000, 16'h0000);
                default: set_regs(4'($urandom_range(1, 15)), 8'($urandom), rand_tick(5),
                                  rand_tick(30), rand_tick(6));
            endcase
            // long receiver stall while items keep coming
            if (ph == 3)
                sink_hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_scan(next_pins(), ROW_PREDICT, EV_NONE, 1'b0);
        end

        // long press on button 0, no idling from here on
        idle_on = 1'b0;
        set_regs(4'd1, 8'h00, 16'h0000, 16'hFFFF, 16'h0000);
        for (int k = 0; k < TAIL_ITEMS; k++)
            send_scan({7'($urandom), 1'b0}, ROW_PREDICT, EV_NONE, 1'b0);
        send_scan(8'h01, ROW_PREDICT, EV_NONE, 1'b0);
        send_scan(8'hFF, ROW_PREDICT, EV_NONE, 1'b0);

        wait_idle();
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
